// ===== rtl/core/w4ge_pkg.sv =====
// ----------------------------------------------------------------------------
// w4ge_pkg
// Shared types, division constants and glyph tables of the four-glyph
// word encoder.
// ----------------------------------------------------------------------------
package w4ge_pkg;

	// word layout
	localparam int WordW  = 16;
	localparam int ValueW = 15;
	localparam int GlyphW = 10;
	localparam int DigitW = 4;

	// reciprocal constants for the mixed-radix split
	localparam logic [15:0] RecipR = 16'd59653;   // ceil(2^27 / 2250)
	localparam int          ShiftR = 27;
	localparam logic [11:0] DivR   = 12'd2250;
	localparam logic [15:0] RecipC = 16'd55925;   // ceil(2^23 / 150)
	localparam int          ShiftC = 23;
	localparam logic [7:0]  DivC   = 8'd150;
	localparam logic [15:0] RecipN = 16'd52429;   // ceil(2^19 / 10)
	localparam int          ShiftN = 19;
	localparam logic [3:0]  DivN   = 4'd10;

	typedef logic [GlyphW-1:0] glyph_t;

	// four digits and the order select of one word
	typedef struct packed {
		logic [DigitW-1:0] r;
		logic [DigitW-1:0] c;
		logic [DigitW-1:0] n;
		logic [DigitW-1:0] b;
		logic              swap;
	} digits_t;

	// four code points in output order
	typedef struct packed {
		glyph_t g0;
		glyph_t g1;
		glyph_t g2;
		glyph_t g3;
	} glyph_set_t;

	// side information carried along the pipeline
	typedef struct packed {
		logic swap;
		logic fin;
	} side_t;

	// r digit table
	function automatic glyph_t glyph_r(input logic [DigitW-1:0] d);
		glyph_t g;
		case (d)
			4'd0:    g = 10'd114;
			4'd1:    g = 10'd82;
			4'd2:    g = 10'd340;
			4'd3:    g = 10'd341;
			4'd4:    g = 10'd342;
			4'd5:    g = 10'd343;
			4'd6:    g = 10'd344;
			4'd7:    g = 10'd345;
			4'd8:    g = 10'd422;
			4'd9:    g = 10'd528;
			4'd10:   g = 10'd529;
			4'd11:   g = 10'd530;
			4'd12:   g = 10'd531;
			4'd13:   g = 10'd588;
			4'd14:   g = 10'd589;
			default: g = '0;
		endcase
		return g;
	endfunction

	// c digit table
	function automatic glyph_t glyph_c(input logic [DigitW-1:0] d);
		glyph_t g;
		case (d)
			4'd0:    g = 10'd99;
			4'd1:    g = 10'd67;
			4'd2:    g = 10'd262;
			4'd3:    g = 10'd263;
			4'd4:    g = 10'd264;
			4'd5:    g = 10'd265;
			4'd6:    g = 10'd266;
			4'd7:    g = 10'd267;
			4'd8:    g = 10'd268;
			4'd9:    g = 10'd269;
			4'd10:   g = 10'd391;
			4'd11:   g = 10'd392;
			4'd12:   g = 10'd199;
			4'd13:   g = 10'd571;
			4'd14:   g = 10'd572;
			default: g = '0;
		endcase
		return g;
	endfunction

	// n digit table
	function automatic glyph_t glyph_n(input logic [DigitW-1:0] d);
		glyph_t g;
		case (d)
			4'd0:    g = 10'd110;
			4'd1:    g = 10'd78;
			4'd2:    g = 10'd323;
			4'd3:    g = 10'd324;
			4'd4:    g = 10'd325;
			4'd5:    g = 10'd326;
			4'd6:    g = 10'd327;
			4'd7:    g = 10'd328;
			4'd8:    g = 10'd413;
			4'd9:    g = 10'd414;
			4'd10:   g = 10'd209;
			4'd11:   g = 10'd504;
			4'd12:   g = 10'd505;
			4'd13:   g = 10'd544;
			4'd14:   g = 10'd565;
			default: g = '0;
		endcase
		return g;
	endfunction

	// b digit table
	function automatic glyph_t glyph_b(input logic [DigitW-1:0] d);
		glyph_t g;
		case (d)
			4'd0:    g = 10'd98;
			4'd1:    g = 10'd66;
			4'd2:    g = 10'd384;
			4'd3:    g = 10'd385;
			4'd4:    g = 10'd387;
			4'd5:    g = 10'd388;
			4'd6:    g = 10'd389;
			4'd7:    g = 10'd223;
			4'd8:    g = 10'd222;
			4'd9:    g = 10'd254;
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

// ===== rtl/core/word_to_four_glyph_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// word_to_four_glyph_encoder_unit
// Encodes one 16-bit word into four 10-bit code points per request.
// ----------------------------------------------------------------------------
// The unit takes one request per clock cycle while in_stall is low and
// returns one result per request, in order, from a six-stage pipeline: a
// reciprocal multiply for the top digit, its remainder, a reciprocal
// multiply for the second digit, its remainder, a reciprocal multiply for
// the third digit, and the last digit with the table lookup and ordering
// into the output register. Each stage holds its own valid bit, so a stall
// on the result side fills empty stages first and reaches in_stall only
// once every stage holds a request.
module word_to_four_glyph_encoder_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// request channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [w4ge_pkg::WordW-1:0]     word,
	input  logic                           final_word,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [w4ge_pkg::GlyphW-1:0]    glyph0,
	output logic [w4ge_pkg::GlyphW-1:0]    glyph1,
	output logic [w4ge_pkg::GlyphW-1:0]    glyph2,
	output logic [w4ge_pkg::GlyphW-1:0]    glyph3,
	output logic                           final_out
);

	localparam int ProdRW = w4ge_pkg::ValueW + 16;
	localparam int ProdCW = 12 + 16;
	localparam int ProdNW = 8 + 16;

	// stage valid bits and readiness
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	// stage payload
	logic [ProdRW-1:0]               prod_r_s1;
	logic [w4ge_pkg::ValueW-1:0]     v_s1;
	w4ge_pkg::side_t                 side_s1;

	logic [w4ge_pkg::DigitW-1:0]     r_s2;
	logic [11:0]                     rem1_s2;
	w4ge_pkg::side_t                 side_s2;

	logic [w4ge_pkg::DigitW-1:0]     r_s3, c_s3;
	logic [11:0]                     rem1_s3;
	w4ge_pkg::side_t                 side_s3;

	logic [w4ge_pkg::DigitW-1:0]     r_s4, c_s4;
	logic [7:0]                      rem2_s4;
	w4ge_pkg::side_t                 side_s4;

	logic [w4ge_pkg::DigitW-1:0]     r_s5, c_s5, n_s5;
	logic [7:0]                      rem2_s5;
	w4ge_pkg::side_t                 side_s5;

	w4ge_pkg::glyph_set_t            glyphs_s6;
	logic                            fin_s6;

	// combinational stage results
	logic [w4ge_pkg::ValueW-1:0]     rprod_w;
	logic [w4ge_pkg::DigitW-1:0]     r_w;
	logic [ProdCW-1:0]               prod_c_w;
	logic [11:0]                     cprod_w;
	logic [ProdNW-1:0]               prod_n_w;
	logic [7:0]                      nprod_w;
	logic [w4ge_pkg::DigitW-1:0]     b_w;
	w4ge_pkg::digits_t               digits_w;
	w4ge_pkg::glyph_set_t            glyphs_w;

	// ready chain, a stage moves when it is empty or the next one moves
	assign rdy6     = !valid_s6 || !out_stall;
	assign rdy5     = !valid_s5 || rdy6;
	assign rdy4     = !valid_s4 || rdy5;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_stall = !rdy1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
			if (rdy6) valid_s6 <= valid_s5;
		end
	end

	// stage 1: reciprocal multiply for the top digit
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			prod_r_s1    <= ProdRW'(word[w4ge_pkg::ValueW-1:0]) *
			                ProdRW'(w4ge_pkg::RecipR);
			v_s1         <= word[w4ge_pkg::ValueW-1:0];
			side_s1.swap <= word[w4ge_pkg::WordW-1];
			side_s1.fin  <= final_word;
		end
	end

	// stage 2: top digit and its remainder
	assign r_w     = prod_r_s1[w4ge_pkg::ShiftR +: w4ge_pkg::DigitW];
	assign rprod_w = w4ge_pkg::ValueW'(r_w) * w4ge_pkg::ValueW'(w4ge_pkg::DivR);

	always_ff @(posedge clk) begin
		if (rdy2 && valid_s1) begin
			r_s2    <= r_w;
			rem1_s2 <= 12'(v_s1 - rprod_w);
			side_s2 <= side_s1;
		end
	end

	// stage 3: reciprocal multiply for the second digit
	assign prod_c_w = ProdCW'(rem1_s2) * ProdCW'(w4ge_pkg::RecipC);

	always_ff @(posedge clk) begin
		if (rdy3 && valid_s2) begin
			r_s3    <= r_s2;
			c_s3    <= prod_c_w[w4ge_pkg::ShiftC +: w4ge_pkg::DigitW];
			rem1_s3 <= rem1_s2;
			side_s3 <= side_s2;
		end
	end

	// stage 4: remainder below 150
	assign cprod_w = 12'(c_s3) * 12'(w4ge_pkg::DivC);

	always_ff @(posedge clk) begin
		if (rdy4 && valid_s3) begin
			r_s4    <= r_s3;
			c_s4    <= c_s3;
			rem2_s4 <= 8'(rem1_s3 - cprod_w);
			side_s4 <= side_s3;
		end
	end

	// stage 5: reciprocal multiply for the third digit
	assign prod_n_w = ProdNW'(rem2_s4) * ProdNW'(w4ge_pkg::RecipN);

	always_ff @(posedge clk) begin
		if (rdy5 && valid_s4) begin
			r_s5    <= r_s4;
			c_s5    <= c_s4;
			n_s5    <= prod_n_w[w4ge_pkg::ShiftN +: w4ge_pkg::DigitW];
			rem2_s5 <= rem2_s4;
			side_s5 <= side_s4;
		end
	end

	// stage 6: last digit, lookup and ordering
	assign nprod_w = 8'(n_s5) * 8'(w4ge_pkg::DivN);
	assign b_w     = w4ge_pkg::DigitW'(rem2_s5 - nprod_w);

	assign digits_w.r    = r_s5;
	assign digits_w.c    = c_s5;
	assign digits_w.n    = n_s5;
	assign digits_w.b    = b_w;
	assign digits_w.swap = side_s5.swap;

	w4ge_glyph_map u_glyph_map (
		.digits (digits_w),
		.glyphs (glyphs_w)
	);

	always_ff @(posedge clk) begin
		if (rdy6 && valid_s5) begin
			glyphs_s6 <= glyphs_w;
			fin_s6    <= side_s5.fin;
		end
	end

	// result port
	assign out_valid = valid_s6;
	assign glyph0    = glyphs_s6.g0;
	assign glyph1    = glyphs_s6.g1;
	assign glyph2    = glyphs_s6.g2;
	assign glyph3    = glyphs_s6.g3;
	assign final_out = fin_s6;

`ifndef ASSERT_OFF
	// an accepted request always lands in the first stage
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted request did not reach stage 1");

	// top digit stays inside its table and remainder below 2250
	a_rem1_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (r_s2 <= 4'd14) && (rem1_s2 < w4ge_pkg::DivR))
		else $error("top digit or its remainder out of range");

	// second digit stays inside its table and remainder below 150
	a_rem2_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> (c_s4 <= 4'd14) && (rem2_s4 < w4ge_pkg::DivC))
		else $error("second digit or its remainder out of range");

	// third digit is the exact quotient by ten
	a_last_digit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> (rem2_s5 >= nprod_w) && (b_w < w4ge_pkg::DivN))
		else $error("third digit quotient is wrong");

	// a held result keeps the pipeline from overwriting it
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 && out_stall |=> $stable(glyphs_s6) && $stable(fin_s6))
		else $error("stalled result changed");
`endif

endmodule

// ===== rtl/core/w4ge_glyph_map.sv =====
// ----------------------------------------------------------------------------
// w4ge_glyph_map
// Looks up the code point of each digit and puts the four code points in
// output order, swapping the two halves when the top word bit is set.
// ----------------------------------------------------------------------------
module w4ge_glyph_map (
	input  w4ge_pkg::digits_t    digits,
	output w4ge_pkg::glyph_set_t glyphs
);

	w4ge_pkg::glyph_t gr, gc, gn, gb;

	// per-digit table lookup
	assign gr = w4ge_pkg::glyph_r(digits.r);
	assign gc = w4ge_pkg::glyph_c(digits.c);
	assign gn = w4ge_pkg::glyph_n(digits.n);
	assign gb = w4ge_pkg::glyph_b(digits.b);

	// output order
	always_comb begin
		if (digits.swap) begin
			glyphs.g0 = gn;
			glyphs.g1 = gb;
			glyphs.g2 = gr;
			glyphs.g3 = gc;
		end else begin
			glyphs.g0 = gr;
			glyphs.g1 = gc;
			glyphs.g2 = gn;
			glyphs.g3 = gb;
		end
	end

endmodule
